FILE: sv/qslerp_pkg.sv
package qslerp_pkg;

    // Defaults for the top-level parameters.
    localparam int CMP_BITS_DEF    = 16;
    localparam int TRIG_STAGES_DEF = 16;

    // Angle and trig datapath width (Q.30 angles with headroom for CORDIC gain).
    localparam int CW         = 34;
    // Square root remainder and root width.
    localparam int SQ_W       = 62;
    localparam int SQRT_STEPS = 31;
    // Divider remainder width and quotient bits.
    localparam int DIV_W      = 64;
    localparam int DIV_STEPS  = 32;

    localparam int              W_BITS    = 17;
    localparam logic [W_BITS-1:0] W_ONE   = 17'd65536;
    localparam logic [14:0]     THR_RESET = 15'd32604;

    // Register select taken from paddr[2].
    localparam logic REG_THR = 1'b0;

    // Arctangent of 2^-k in Q.30.
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef enum logic {
        CORDIC_VECTOR,
        CORDIC_ROTATE
    } t_cordic_mode;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        logic [30:0]     dq;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [31:0]      den;
        logic [31:0]      quo;
        logic             neg;
        logic             ovf;
        logic             deg;
    } t_div;

endpackage

FILE: sv/qslerp_if.sv
interface qslerp_in_if import qslerp_pkg::*; #(
    parameter int COMPONENT_BITS = CMP_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] a_x;
    logic signed [COMPONENT_BITS-1:0] a_y;
    logic signed [COMPONENT_BITS-1:0] a_z;
    logic signed [COMPONENT_BITS-1:0] a_w;
    logic signed [COMPONENT_BITS-1:0] b_x;
    logic signed [COMPONENT_BITS-1:0] b_y;
    logic signed [COMPONENT_BITS-1:0] b_z;
    logic signed [COMPONENT_BITS-1:0] b_w;
    logic [W_BITS-1:0]                blend_weight;

    modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend_weight,
                    input ready);
    modport sink   (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend_weight,
                    output ready);
endinterface

interface qslerp_out_if import qslerp_pkg::*; #(
    parameter int COMPONENT_BITS = CMP_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] r_x;
    logic signed [COMPONENT_BITS-1:0] r_y;
    logic signed [COMPONENT_BITS-1:0] r_z;
    logic signed [COMPONENT_BITS-1:0] r_w;
    logic                             used_linear;

    modport source (output valid, r_x, r_y, r_z, r_w, used_linear, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_w, used_linear, output ready);
endinterface

FILE: sv/quaternion_slerp_unit.sv
// Throughput: one item per cycle; every stage holds while the output item waits.
// The rate is set by a single pipeline of cells: products, square root, CORDIC and divider.
// Reset (i_rst_n low at a clock edge) empties the pipeline and loads the threshold default.
// The data registers are not reset; they carry no meaning until a valid bit reaches them.
module quaternion_slerp_unit import qslerp_pkg::*; #(
    parameter int COMPONENT_BITS = CMP_BITS_DEF,
    parameter int TRIG_STAGES    = TRIG_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qslerp_in_if.sink     i_in,
    qslerp_out_if.source  o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int N       = COMPONENT_BITS;
    localparam int F       = N - 1;
    // Delay from the dot-product stage to the final scaling stage.
    localparam int SIDE_D  = 66 + 2 * TRIG_STAGES;
    // Tap where the weight meets theta at the phase split.
    localparam int PH_TAP  = 32 + TRIG_STAGES;
    localparam int LAT     = SIDE_D + 4;
    localparam int TW      = N + 35;

    localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< F) - 64'sd1);
    localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);
    localparam logic [32:0]          SC_LIM = 33'(1) << 31;

    // Quaternion a (sign-corrected), b, weight and the early linear decision
    // travel alongside the trig pipeline.
    typedef struct packed {
        logic [3:0][N:0]     an;
        logic [3:0][N-1:0]   b;
        logic [W_BITS-1:0]   w;
        logic                lin;
    } t_side;

    logic w_en;
    logic [LAT-1:0] r_vld;

    // The whole pipeline advances unless the output item is stalled.
    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // ------------------------------------------------------------------
    // Configuration register. Only bit 2 of the address selects anything;
    // the single register sits at offset zero.
    // ------------------------------------------------------------------
    logic [14:0] r_thr;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THR) ? {17'b0, r_thr} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THR)) begin
            r_thr <= pwdata[14:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the item, form the four products and clamp the weight.
    // ------------------------------------------------------------------
    logic signed [N-1:0]   w_ain [4];
    logic signed [N-1:0]   w_bin [4];
    logic signed [N-1:0]   r_a1  [4];
    logic signed [N-1:0]   r_b1  [4];
    logic signed [2*N-1:0] r_p1  [4];
    logic [W_BITS-1:0]     r_w1;

    assign w_ain[0] = i_in.a_x;
    assign w_ain[1] = i_in.a_y;
    assign w_ain[2] = i_in.a_z;
    assign w_ain[3] = i_in.a_w;
    assign w_bin[0] = i_in.b_x;
    assign w_bin[1] = i_in.b_y;
    assign w_bin[2] = i_in.b_z;
    assign w_bin[3] = i_in.b_w;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_a1[i] <= w_ain[i];
                r_b1[i] <= w_bin[i];
                r_p1[i] <= w_ain[i] * w_bin[i];
            end
            r_w1 <= (i_in.blend_weight > W_ONE) ? W_ONE : i_in.blend_weight;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot product, sign fold, threshold compare and the Q.30 dot.
    // ------------------------------------------------------------------
    logic signed [2*N-1:0] w_sum;
    logic signed [2*N-1:0] w_dotw;
    logic signed [N+2:0]   w_dot;
    logic [N+1:0]          w_adot;
    logic [N+1:0]          w_thr_f;
    logic                  w_neg;
    logic [30:0]           w_dq;
    logic signed [N:0]     w_an [4];

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 4; i++) begin
            w_sum = w_sum + (r_p1[i] >>> 2);
        end
        w_dotw  = w_sum >>> (N - 3);
        w_dot   = w_dotw[N+2:0];
        w_neg   = w_dot[N+2];
        w_adot  = w_neg ? (N+2)'(-w_dot) : (N+2)'(w_dot);
        // The threshold is unsigned Q0.15; align it to the component's binary point.
        w_thr_f = (N+2)'((64'(r_thr) << F) >> 15);
        // Only meaningful on the slerp path, where the dot is below one.
        w_dq    = 31'((64'(w_adot) << 30) >> F);
        for (int i = 0; i < 4; i++) begin
            w_an[i] = w_neg ? -((N+1)'(r_a1[i])) : (N+1)'(r_a1[i]);
        end
    end

    t_side      r_side [SIDE_D+1];
    logic [30:0] r_dq2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_side[0].an[i] <= w_an[i];
                r_side[0].b[i]  <= r_b1[i];
            end
            r_side[0].w   <= r_w1;
            r_side[0].lin <= (w_adot >= w_thr_f);
            r_dq2         <= w_dq;
            for (int j = 1; j <= SIDE_D; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: square the dot; the root cells then form sqrt(1 - dot^2).
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] r_sq3;
    logic [30:0]     r_dq3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq3 <= r_dq2 * r_dq2;
            r_dq3 <= r_dq2;
        end
    end

    t_sqrt w_sq [SQRT_STEPS+1];

    assign w_sq[0].rem  = (SQ_W'(1) << 60) - r_sq3;
    assign w_sq[0].root = '0;
    assign w_sq[0].dq   = r_dq3;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        qslerp_sqrt_cell #(
            .BIT_POS (2 * (SQRT_STEPS - 1 - j))
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[j]),
            .o_q   (w_sq[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Vectoring cells: theta = atan2(sqrt(1 - dot^2), dot) = acos(dot).
    // ------------------------------------------------------------------
    t_cordic w_vec [TRIG_STAGES+1];

    assign w_vec[0].x = $signed(CW'(w_sq[SQRT_STEPS].dq));
    assign w_vec[0].y = $signed(CW'(w_sq[SQRT_STEPS].root[30:0]));
    assign w_vec[0].z = '0;

    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_vec
        qslerp_cordic_cell #(
            .SHIFT (i % 32),
            .MODE  (CORDIC_VECTOR)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_vec[i]),
            .o_q   (w_vec[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Phase split: w*theta by floor, (1-w)*theta as the remainder.
    // ------------------------------------------------------------------
    logic signed [CW+W_BITS:0] w_phprod;
    logic signed [CW-1:0]      r_theta;
    logic signed [CW-1:0]      r_ph2;

    assign w_phprod = w_vec[TRIG_STAGES].z * $signed({1'b0, r_side[PH_TAP].w});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_theta <= w_vec[TRIG_STAGES].z;
            r_ph2   <= CW'(w_phprod >>> 16);
        end
    end

    // ------------------------------------------------------------------
    // Three rotation lanes: sin(theta), sin((1-w)theta), sin(w*theta).
    // The CORDIC gain is common to all three and cancels in the ratios.
    // ------------------------------------------------------------------
    t_cordic w_sin [3][TRIG_STAGES+1];

    assign w_sin[0][0].z = r_theta;
    assign w_sin[1][0].z = r_theta - r_ph2;
    assign w_sin[2][0].z = r_ph2;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_sin[l][0].x = $signed(CW'(1) << 30);
        assign w_sin[l][0].y = '0;
        for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_sin
            qslerp_cordic_cell #(
                .SHIFT (i % 32),
                .MODE  (CORDIC_ROTATE)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_sin[l][i]),
                .o_q   (w_sin[l][i+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: magnitude of sin_part * 2^30 over sin(theta). A
    // quotient of 2^32 or more is caught here and clamped later.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_yt;
    logic                 w_deg;
    t_div                 w_prep [2];
    t_div                 w_div  [2][DIV_STEPS+1];

    assign w_yt  = w_sin[0][TRIG_STAGES].y;
    assign w_deg = w_yt[CW-1] || (w_yt == '0);

    always_comb begin
        logic signed [CW-1:0] sp;
        logic [CW-1:0]        mag;
        for (int l = 0; l < 2; l++) begin
            sp               = w_sin[l+1][TRIG_STAGES].y;
            mag              = sp[CW-1] ? CW'(-sp) : CW'(sp);
            w_prep[l].rem    = DIV_W'(mag) << 30;
            w_prep[l].den    = w_yt[31:0];
            w_prep[l].quo    = '0;
            w_prep[l].neg    = sp[CW-1];
            w_prep[l].ovf    = (w_prep[l].rem >> 32) >= DIV_W'(w_yt[31:0]);
            w_prep[l].deg    = w_deg;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_dlane
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                w_div[l][0] <= w_prep[l];
            end
        end
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
            qslerp_div_cell #(
                .QBIT (DIV_STEPS - 1 - j)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_div[l][j]),
                .o_q   (w_div[l][j+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Final scaling: pick slerp or linear scales and form the products.
    // A non-positive sin(theta) also forces the linear blend.
    // ------------------------------------------------------------------
    logic signed [32:0]   w_sc  [2];
    logic [32:0]          w_mag [2];
    logic signed [32:0]   w_s1;
    logic signed [32:0]   w_s2;
    logic                 w_lin;
    logic signed [N+33:0] r_pa [4];
    logic signed [N+33:0] r_pb [4];
    logic                 r_lin;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_mag[l] = (w_div[l][DIV_STEPS].ovf || (w_div[l][DIV_STEPS].quo > 32'h8000_0000))
                       ? SC_LIM : {1'b0, w_div[l][DIV_STEPS].quo};
            w_sc[l]  = w_div[l][DIV_STEPS].neg ? $signed(-w_mag[l]) : $signed(w_mag[l]);
        end
        w_lin = r_side[SIDE_D].lin || w_div[0][DIV_STEPS].deg;
        if (w_lin) begin
            w_s1 = $signed({2'b0, W_ONE - r_side[SIDE_D].w, 14'b0});
            w_s2 = $signed({2'b0, r_side[SIDE_D].w, 14'b0});
        end else begin
            w_s1 = w_sc[0];
            w_s2 = w_sc[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_pa[i] <= w_s1 * $signed(r_side[SIDE_D].an[i]);
                r_pb[i] <= w_s2 * $signed(r_side[SIDE_D].b[i]);
            end
            r_lin <= w_lin;
        end
    end

    // ------------------------------------------------------------------
    // Output register: sum, round half up, saturate.
    // ------------------------------------------------------------------
    logic signed [TW-1:0] w_t   [4];
    logic signed [TW-1:0] w_rnd [4];
    logic signed [N-1:0]  w_sat [4];
    logic signed [N-1:0]  r_res [4];
    logic                 r_lin_o;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_t[i]   = TW'(r_pa[i] >>> 1) + TW'(r_pb[i] >>> 1);
            w_rnd[i] = (w_t[i] + TW'(1 << 28)) >>> 29;
            if (w_rnd[i] > SAT_HI) begin
                w_sat[i] = N'(SAT_HI);
            end else if (w_rnd[i] < SAT_LO) begin
                w_sat[i] = N'(SAT_LO);
            end else begin
                w_sat[i] = N'(w_rnd[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_res[i] <= w_sat[i];
            end
            r_lin_o <= r_lin;
        end
    end

    assign o_out.valid       = r_vld[LAT-1];
    assign o_out.r_x         = r_res[0];
    assign o_out.r_y         = r_res[1];
    assign o_out.r_z         = r_res[2];
    assign o_out.r_w         = r_res[3];
    assign o_out.used_linear = r_lin_o;

endmodule

FILE: sv/qslerp_sqrt_cell.sv
module qslerp_sqrt_cell import qslerp_pkg::*; #(
    parameter int BIT_POS = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sqrt i_d,
    output t_sqrt o_q
);
    // One result bit per cell of the digit-by-digit integer square root.
    localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << BIT_POS;

    logic [SQ_W-1:0] trial;
    t_sqrt           n_q;
    t_sqrt           r_q;

    always_comb begin
        trial = i_d.root + BIT_VAL;
        n_q   = i_d;
        if (i_d.rem >= trial) begin
            n_q.rem  = i_d.rem - trial;
            n_q.root = (i_d.root >> 1) + BIT_VAL;
        end else begin
            n_q.root = i_d.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

FILE: sv/qslerp_cordic_cell.sv
module qslerp_cordic_cell import qslerp_pkg::*; #(
    parameter int           SHIFT = 0,
    parameter t_cordic_mode MODE  = CORDIC_ROTATE
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_d,
    output t_cordic o_q
);
    localparam logic signed [CW-1:0] ANG = $signed(CW'(ATAN_Q30[SHIFT]));

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 dir;
    t_cordic              n_q;
    t_cordic              r_q;

    always_comb begin
        dx = i_d.y >>> SHIFT;
        dy = i_d.x >>> SHIFT;
        // Vectoring drives y toward zero; rotation drives z toward zero.
        dir = (MODE == CORDIC_VECTOR) ? i_d.y[CW-1] : !i_d.z[CW-1];
        if (dir) begin
            n_q.x = i_d.x - dx;
            n_q.y = i_d.y + dy;
            n_q.z = i_d.z - ANG;
        end else begin
            n_q.x = i_d.x + dx;
            n_q.y = i_d.y - dy;
            n_q.z = i_d.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

FILE: sv/qslerp_div_cell.sv
module qslerp_div_cell import qslerp_pkg::*; #(
    parameter int QBIT = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_q
);
    // One restoring step: decides quotient bit QBIT.
    logic [DIV_W-1:0] dsh;
    t_div             n_q;
    t_div             r_q;

    always_comb begin
        dsh = DIV_W'(i_d.den) << QBIT;
        n_q = i_d;
        if (i_d.rem >= dsh) begin
            n_q.rem       = i_d.rem - dsh;
            n_q.quo[QBIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
